// ===== rtl/core/tfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tfa_pkg
// Shared types and constants of the topic filter threshold alarm block.
// ----------------------------------------------------------------------------
package tfa_pkg;

    // default sizes
    localparam int RULES_DEF      = 16;
    localparam int FILTER_LEN_DEF = 64;
    localparam int MAX_ALARMS     = 16;

    // filter characters with a special meaning
    localparam logic [7:0] CH_MULTI  = 8'h23;
    localparam logic [7:0] CH_SINGLE = 8'h2B;
    localparam logic [7:0] CH_SEP    = 8'h2F;

    // operation codes
    localparam logic [1:0] OP_FILTER = 2'd0;
    localparam logic [1:0] OP_LIMITS = 2'd1;
    localparam logic [1:0] OP_TOPIC  = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    // match status codes
    localparam logic [1:0] ST_ACTIVE  = 2'd0;
    localparam logic [1:0] ST_MATCHED = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;

    // default limits, plus and minus 999999 in Q31.16
    localparam logic signed [47:0] BOUND_HI = 48'sh000F423F0000;
    localparam logic signed [47:0] BOUND_LO = 48'shFFF0BDC10000;
    localparam logic [1:0]         SEV_DEF  = 2'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         rule_index;
        logic [5:0]         char_pos;
        logic [7:0]         char_value;
        logic signed [47:0] low_limit;
        logic signed [47:0] high_limit;
        logic [1:0]         alarm_level;
        logic signed [47:0] sample_value;
        logic               is_telemetry;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         alarm_rule;
        logic [1:0]         alarm_severity;
        logic signed [47:0] alarm_value;
        logic [31:0]        alarm_number;
        logic               last_alarm;
    } t_out_item;

    typedef struct packed {
        logic signed [47:0] low;
        logic signed [47:0] high;
        logic [1:0]         sev;
    } t_rule;

endpackage

// ===== rtl/core/tfa_filter_ram.sv =====
// ----------------------------------------------------------------------------
// tfa_filter_ram
// Filter character memory, one write and one registered read port, with a
// zero fill sweep after reset.
// ----------------------------------------------------------------------------
module tfa_filter_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata,
    output logic          o_busy
);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic          r_busy;

    // clear sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_busy     <= 1'b1;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

// ===== rtl/core/tfa_rule_store.sv =====
// ----------------------------------------------------------------------------
// tfa_rule_store
// Limits and severity per rule; a rule never written reads the defaults.
// ----------------------------------------------------------------------------
module tfa_rule_store #(
    parameter int RULES = 16,
    parameter int RW    = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_we,
    input  logic [RW-1:0]  i_waddr,
    input  tfa_pkg::t_rule i_wdata,
    input  logic [RW-1:0]  i_raddr,
    output tfa_pkg::t_rule o_rdata
);
    import tfa_pkg::*;

    t_rule            r_mem [RULES];
    t_rule            r_rdata;
    logic             r_rd_valid;
    logic [RULES-1:0] r_valid;

    // written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd_valid ? r_rdata : t_rule'{BOUND_LO, BOUND_HI, SEV_DEF};

endmodule

// ===== rtl/core/tfa_cursor_store.sv =====
// ----------------------------------------------------------------------------
// tfa_cursor_store
// Match cursor, skip flag and status per rule; cleared at once by
// dropping the valid flags, an invalid entry reads as zero.
// ----------------------------------------------------------------------------
module tfa_cursor_store #(
    parameter int RULES = 16,
    parameter int RW    = 4,
    parameter int DW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_we,
    input  logic [RW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [RW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0]    r_mem [RULES];
    logic [DW-1:0]    r_rdata;
    logic             r_rd_valid;
    logic [RULES-1:0] r_valid;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clr) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_raddr] && !i_clr;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

// ===== rtl/core/topic_filter_threshold_alarm.sv =====
// Sequence: writes are taken when idle; a topic char visits every rule, with
// an evaluate step per rule that steps its cursor and per '+' at a '/'; an end
// item visits each rule in use, evaluates each active one and waits on stalls.
// Throughput: one item at a time, set by the shared matcher visiting each rule.
// Reset: synchronous active low; the filter memory is then zero filled before
// the first item is taken.
// ----------------------------------------------------------------------------
// topic_filter_threshold_alarm
// Wildcard topic filter match per rule with limit check and alarm output.
// ----------------------------------------------------------------------------
module topic_filter_threshold_alarm #(
    parameter int RULES      = tfa_pkg::RULES_DEF,
    parameter int FILTER_LEN = tfa_pkg::FILTER_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tfa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tfa_pkg::t_out_item o_out_item
);
    import tfa_pkg::*;

    localparam int RW     = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int PW     = $clog2(FILTER_LEN);
    localparam int CW     = $clog2(FILTER_LEN + 1);
    localparam int FAW    = RW + PW;
    localparam int FDEPTH = RULES << PW;
    localparam int CSW    = CW + 3;

    typedef struct packed {
        logic [1:0]    stat;
        logic          skip;
        logic [CW-1:0] cur;
    } t_cursor;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CRD, S_CHK, S_EVAL, S_FLUSH
    } t_state;

    t_state             r_state, n_state;
    logic [RW-1:0]      r_rule, n_rule;
    logic [RW-1:0]      r_last, n_last;
    logic               r_end, n_end;
    logic [7:0]         r_ch, n_ch;
    logic signed [47:0] r_sample, n_sample;
    logic [CW-1:0]      r_cur, n_cur;
    logic               r_skip, n_skip;
    logic [1:0]         r_stat, n_stat;
    logic               r_fend, n_fend;
    logic               r_pend_v, n_pend_v;
    t_out_item          r_pend, n_pend;
    logic               r_out_v, n_out_v;
    t_out_item          r_out, n_out;
    logic [31:0]        r_seq, n_seq;
    logic [4:0]         r_cnt, n_cnt;
    logic [4:0]         r_rc, n_rc;

    logic               fr_busy;
    logic [7:0]         fr_data;
    logic               fw_we;
    logic               rw_we;
    logic               cw_we;
    logic               cw_clr;
    logic [CW-1:0]      rd_pos;
    logic [RW-1:0]      in_rule;
    logic [PW-1:0]      in_pos;
    logic               in_rule_ok;
    logic               in_pos_ok;
    logic [RW:0]        limit;
    logic [7:0]         f_char;
    t_rule              rs_data;
    t_cursor            cs_data;
    logic [CSW-1:0]     cs_raw;
    logic               out_range;
    logic               out_free;
    logic               hit;
    logic               adv;

    // address decode of the input item
    assign in_rule    = RW'(i_in_item.rule_index);
    assign in_pos     = PW'(i_in_item.char_pos);
    assign in_rule_ok = 32'(i_in_item.rule_index) < 32'(RULES);
    assign in_pos_ok  = 32'(i_in_item.char_pos) < 32'(FILTER_LEN);
    assign limit      = (32'(r_rc) >= 32'(RULES)) ? (RW + 1)'(RULES) : (RW + 1)'(r_rc);

    // storage units
    tfa_filter_ram #(
        .DEPTH (FDEPTH),
        .AW    (FAW)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (fw_we),
        .i_waddr ({in_rule, in_pos}),
        .i_wdata (i_in_item.char_value),
        .i_raddr ({r_rule, rd_pos[PW-1:0]}),
        .o_rdata (fr_data),
        .o_busy  (fr_busy)
    );

    tfa_rule_store #(
        .RULES (RULES),
        .RW    (RW)
    ) u_rules (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rw_we),
        .i_waddr (in_rule),
        .i_wdata (t_rule'{i_in_item.low_limit, i_in_item.high_limit,
                          i_in_item.alarm_level}),
        .i_raddr (r_rule),
        .o_rdata (rs_data)
    );

    tfa_cursor_store #(
        .RULES (RULES),
        .RW    (RW),
        .DW    (CSW)
    ) u_cursors (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (cw_clr),
        .i_we    (cw_we),
        .i_waddr (r_rule),
        .i_wdata ({n_stat, n_skip, n_cur}),
        .i_raddr (r_rule),
        .o_rdata (cs_raw)
    );

    assign cs_data   = t_cursor'(cs_raw);
    assign f_char    = r_fend ? 8'd0 : fr_data;
    assign out_range = (r_sample < rs_data.low) || (r_sample > rs_data.high);
    assign out_free  = !r_out_v || i_out_ready;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_rule   = r_rule;
        n_last   = r_last;
        n_end    = r_end;
        n_ch     = r_ch;
        n_sample = r_sample;
        n_cur    = r_cur;
        n_skip   = r_skip;
        n_stat   = r_stat;
        n_fend   = r_fend;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = r_out_v && !i_out_ready;
        n_out    = r_out;
        n_seq    = r_seq;
        n_cnt    = r_cnt;
        n_rc     = i_cfg_we ? i_cfg_data : r_rc;
        fw_we    = 1'b0;
        rw_we    = 1'b0;
        cw_we    = 1'b0;
        cw_clr   = 1'b0;
        rd_pos   = r_cur;
        hit      = 1'b0;
        adv      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                if (!fr_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.operation)
                        OP_FILTER: fw_we = in_rule_ok && in_pos_ok;
                        OP_LIMITS: rw_we = in_rule_ok;
                        OP_TOPIC: begin
                            if (i_in_item.char_value != 8'd0) begin
                                n_rule  = '0;
                                n_last  = RW'(RULES - 1);
                                n_end   = 1'b0;
                                n_ch    = i_in_item.char_value;
                                n_state = S_CRD;
                            end
                        end
                        OP_END: begin
                            n_sample = i_in_item.sample_value;
                            if (i_in_item.is_telemetry && limit != '0) begin
                                n_rule  = '0;
                                n_last  = RW'(limit - 1'b1);
                                n_end   = 1'b1;
                                n_cnt   = '0;
                                n_state = S_CRD;
                            end else begin
                                cw_clr = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CRD: n_state = S_CHK;
            S_CHK: begin
                n_cur  = cs_data.cur;
                n_skip = cs_data.skip;
                n_stat = cs_data.stat;
                rd_pos = cs_data.cur;
                n_fend = 32'(cs_data.cur) >= 32'(FILTER_LEN);
                if (!r_end) begin
                    if (cs_data.stat != ST_ACTIVE || (cs_data.skip && r_ch != CH_SEP)) begin
                        adv = 1'b1;
                    end else begin
                        n_skip  = 1'b0;
                        n_state = S_EVAL;
                    end
                end else if (cs_data.stat == ST_MATCHED) begin
                    hit = out_range;
                    adv = !out_range;
                end else if (cs_data.stat == ST_ACTIVE) begin
                    n_state = S_EVAL;
                end else begin
                    adv = 1'b1;
                end
            end
            S_EVAL: begin
                if (!r_end) begin
                    cw_we = 1'b1;
                    adv   = 1'b1;
                    if (f_char == 8'd0) begin
                        n_stat = ST_FAILED;
                    end else if (f_char == CH_MULTI) begin
                        n_stat = ST_MATCHED;
                    end else if (f_char == CH_SINGLE) begin
                        n_cur = r_cur + 1'b1;
                        if (r_ch != CH_SEP) begin
                            n_skip = 1'b1;
                        end else begin
                            // plus at a separator: step on to the next filter char
                            cw_we  = 1'b0;
                            adv    = 1'b0;
                            rd_pos = n_cur;
                            n_fend = 32'(n_cur) >= 32'(FILTER_LEN);
                        end
                    end else if (f_char == r_ch) begin
                        n_cur = r_cur + 1'b1;
                    end else begin
                        n_stat = ST_FAILED;
                    end
                end else begin
                    hit = (f_char == CH_MULTI || f_char == 8'd0) && out_range;
                    adv = !hit;
                end
            end
            S_FLUSH: begin
                if (r_pend_v) begin
                    if (out_free) begin
                        n_out            = r_pend;
                        n_out.last_alarm = 1'b1;
                        n_out_v          = 1'b1;
                        n_pend_v         = 1'b0;
                        cw_clr           = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    cw_clr  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // alarm: the previous one leaves once the output register is free
        if (hit && (!r_pend_v || out_free)) begin
            if (r_pend_v) begin
                n_out   = r_pend;
                n_out_v = 1'b1;
            end
            n_pend   = t_out_item'{4'(r_rule), rs_data.sev, r_sample, r_seq, 1'b0};
            n_pend_v = 1'b1;
            n_seq    = r_seq + 1'b1;
            n_cnt    = r_cnt + 1'b1;
            adv      = 1'b1;
        end

        // next rule or done
        if (adv) begin
            if (r_rule == r_last || (r_end && n_cnt == 5'(MAX_ALARMS))) begin
                n_state = r_end ? S_FLUSH : S_IDLE;
            end else begin
                n_rule  = r_rule + 1'b1;
                n_state = S_CRD;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_seq    <= '0;
            r_cnt    <= '0;
            r_rc     <= '0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_seq    <= n_seq;
            r_cnt    <= n_cnt;
            r_rc     <= n_rc;
            r_rule   <= n_rule;
            r_last   <= n_last;
            r_end    <= n_end;
            r_ch     <= n_ch;
            r_sample <= n_sample;
            r_cur    <= n_cur;
            r_skip   <= n_skip;
            r_stat   <= n_stat;
            r_fend   <= n_fend;
            r_pend   <= n_pend;
            r_out    <= n_out;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    // checks
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'(MAX_ALARMS))
        else $error("alarm count beyond cap");
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_pend_v)
        else $error("pending alarm left at idle");
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_busy |-> !o_in_ready)
        else $error("item taken during filter clear");
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != $past(r_seq)) |-> $past(hit))
        else $error("sequence number moved without alarm");

endmodule
